@@ hdl/ldsr_pkg.sv @@
// Shared types, constants and the control program of the LCD dirty-span refresher.
package ldsr_pkg;

    localparam int LINES   = 4;
    localparam int CHARS   = 20;
    localparam int DEPTH   = LINES * CHARS;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int ROW_W   = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int COL_W   = 5;
    localparam int IROW_W  = 3;
    localparam int CH_W    = 8;
    localparam int CNT_W   = 10;
    localparam int CFG_W   = 10;
    localparam int TDATA_W = 16;
    localparam int POS_SHIFT = 5;

    localparam logic [CNT_W-1:0] CNT_MAX      = CNT_W'(1023);
    localparam logic [CNT_W-1:0] PERIOD_RESET = CNT_W'(500);
    localparam logic [7:0]       ADDR_RESET   = 8'h94;
    localparam logic [7:0]       SPACE        = 8'h20;
    localparam logic [7:0]       CMD_CLEAR    = 8'h10;
    localparam logic [7:0]       CMD_CURSOR   = 8'h11;
    localparam logic [7:0]       CMD_TEXT     = 8'h00;

    localparam logic CFG_DEV_ADDR = 1'b0;
    localparam logic CFG_PERIOD   = 1'b1;

    typedef enum logic [3:0] {
        A_NONE,
        A_LATCH,
        A_WRITE,
        A_UNWAIT,
        A_CLEAR,
        A_START,
        A_SCAN,
        A_LOAD_FIRST,
        A_CELL,
        A_FINISH,
        A_ADV_ROW
    } act_t;

    typedef enum logic [2:0] {
        SEL_NONE,
        SEL_ADDR,
        SEL_CLEAR,
        SEL_CURSOR,
        SEL_TEXT,
        SEL_POS,
        SEL_CELL
    } sel_t;

    typedef enum logic [1:0] {
        F_NO,
        F_YES,
        F_AT_LAST
    } flag_t;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_ITEM,
        C_IS_WRITE,
        C_WAIT,
        C_CLR_DUE,
        C_SCAN_MORE,
        C_NOT_FOUND,
        C_CELL_MORE
    } cond_t;

    localparam int STEP_W = 5;
    typedef logic [STEP_W-1:0] step_t;

    localparam step_t S_IDLE    = 5'd0;
    localparam step_t S_OPCHK   = 5'd1;
    localparam step_t S_WAITCHK = 5'd2;
    localparam step_t S_CLRCHK  = 5'd3;
    localparam step_t S_START   = 5'd4;
    localparam step_t S_SCAN    = 5'd5;
    localparam step_t S_FOUND   = 5'd6;
    localparam step_t S_CUR0    = 5'd7;
    localparam step_t S_CUR1    = 5'd8;
    localparam step_t S_CUR2    = 5'd9;
    localparam step_t S_DAT0    = 5'd10;
    localparam step_t S_DAT1    = 5'd11;
    localparam step_t S_CELL    = 5'd12;
    localparam step_t S_FINISH  = 5'd13;
    localparam step_t S_ADVROW  = 5'd14;
    localparam step_t S_WRITE   = 5'd15;
    localparam step_t S_UNWAIT  = 5'd16;
    localparam step_t S_CLR0    = 5'd17;
    localparam step_t S_CLR1    = 5'd18;
    localparam step_t S_CLR2    = 5'd19;

    typedef struct packed {
        act_t  act;
        sel_t  sel;
        flag_t eof;
        flag_t lst;
        cond_t cond;
        step_t target;
    } ctrl_t;

    typedef struct packed {
        logic item_valid;
        logic is_write;
        logic wait_set;
        logic clr_due;
        logic scan_more;
        logic not_found;
        logic cell_more;
        logic out_free;
    } stat_t;

    function automatic ctrl_t mk(input act_t act, input sel_t sel, input flag_t eof,
                                 input flag_t lst, input cond_t cond, input step_t target);
        ctrl_t w;
        w.act    = act;
        w.sel    = sel;
        w.eof    = eof;
        w.lst    = lst;
        w.cond   = cond;
        w.target = target;
        return w;
    endfunction

    // Control store: one word per step; a true condition jumps to target.
    function automatic ctrl_t ucode(input step_t step);
        ctrl_t w;
        unique case (step)
            S_IDLE:    w = mk(A_LATCH,      SEL_NONE,   F_NO,      F_NO,      C_NO_ITEM,   S_IDLE);
            S_OPCHK:   w = mk(A_NONE,       SEL_NONE,   F_NO,      F_NO,      C_IS_WRITE,  S_WRITE);
            S_WAITCHK: w = mk(A_NONE,       SEL_NONE,   F_NO,      F_NO,      C_WAIT,      S_UNWAIT);
            S_CLRCHK:  w = mk(A_NONE,       SEL_NONE,   F_NO,      F_NO,      C_CLR_DUE,   S_CLR0);
            S_START:   w = mk(A_START,      SEL_NONE,   F_NO,      F_NO,      C_NEVER,     S_IDLE);
            S_SCAN:    w = mk(A_SCAN,       SEL_NONE,   F_NO,      F_NO,      C_SCAN_MORE, S_SCAN);
            S_FOUND:   w = mk(A_NONE,       SEL_NONE,   F_NO,      F_NO,      C_NOT_FOUND, S_ADVROW);
            S_CUR0:    w = mk(A_NONE,       SEL_ADDR,   F_NO,      F_NO,      C_NEVER,     S_IDLE);
            S_CUR1:    w = mk(A_NONE,       SEL_CURSOR, F_NO,      F_NO,      C_NEVER,     S_IDLE);
            S_CUR2:    w = mk(A_NONE,       SEL_POS,    F_YES,     F_NO,      C_NEVER,     S_IDLE);
            S_DAT0:    w = mk(A_LOAD_FIRST, SEL_ADDR,   F_NO,      F_NO,      C_NEVER,     S_IDLE);
            S_DAT1:    w = mk(A_NONE,       SEL_TEXT,   F_NO,      F_NO,      C_NEVER,     S_IDLE);
            S_CELL:    w = mk(A_CELL,       SEL_CELL,   F_AT_LAST, F_AT_LAST, C_CELL_MORE, S_CELL);
            S_FINISH:  w = mk(A_FINISH,     SEL_NONE,   F_NO,      F_NO,      C_ALWAYS,    S_IDLE);
            S_ADVROW:  w = mk(A_ADV_ROW,    SEL_NONE,   F_NO,      F_NO,      C_ALWAYS,    S_IDLE);
            S_WRITE:   w = mk(A_WRITE,      SEL_NONE,   F_NO,      F_NO,      C_ALWAYS,    S_IDLE);
            S_UNWAIT:  w = mk(A_UNWAIT,     SEL_NONE,   F_NO,      F_NO,      C_ALWAYS,    S_IDLE);
            S_CLR0:    w = mk(A_NONE,       SEL_ADDR,   F_NO,      F_NO,      C_NEVER,     S_IDLE);
            S_CLR1:    w = mk(A_NONE,       SEL_CLEAR,  F_NO,      F_NO,      C_NEVER,     S_IDLE);
            S_CLR2:    w = mk(A_CLEAR,      SEL_TEXT,   F_YES,     F_YES,     C_ALWAYS,    S_IDLE);
            default:   w = mk(A_NONE,       SEL_NONE,   F_NO,      F_NO,      C_ALWAYS,    S_IDLE);
        endcase
        return w;
    endfunction

endpackage

@@ hdl/ldsr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module ldsr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 80
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hdl/ldsr_seq.sv @@
// Microcode sequencer: step counter, control store lookup and conditional jumps.
module ldsr_seq (
    input  logic           clk,
    input  logic           rst_n,
    input  ldsr_pkg::stat_t stat,
    output ldsr_pkg::ctrl_t ctrl,
    output logic           go
);

    ldsr_pkg::step_t step_reg;
    ldsr_pkg::step_t step_next;
    logic            cond_true;

    assign ctrl = ldsr_pkg::ucode(step_reg);

    // A step that emits a word waits until the output register can take it.
    assign go = (ctrl.sel == ldsr_pkg::SEL_NONE) || stat.out_free;

    always_comb
    begin
        unique case (ctrl.cond)
            ldsr_pkg::C_NEVER:     cond_true = 1'b0;
            ldsr_pkg::C_ALWAYS:    cond_true = 1'b1;
            ldsr_pkg::C_NO_ITEM:   cond_true = !stat.item_valid;
            ldsr_pkg::C_IS_WRITE:  cond_true = stat.is_write;
            ldsr_pkg::C_WAIT:      cond_true = stat.wait_set;
            ldsr_pkg::C_CLR_DUE:   cond_true = stat.clr_due;
            ldsr_pkg::C_SCAN_MORE: cond_true = stat.scan_more;
            ldsr_pkg::C_NOT_FOUND: cond_true = stat.not_found;
            ldsr_pkg::C_CELL_MORE: cond_true = stat.cell_more;
            default:               cond_true = 1'b1;
        endcase
    end

    always_comb
    begin
        step_next = step_reg;
        if (go)
        begin
            step_next = cond_true ? ctrl.target : step_reg + ldsr_pkg::step_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= ldsr_pkg::S_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

@@ hdl/ldsr_dp.sv @@
// Datapath: frame and shadow stores, row scan, byte selection and output register.
module ldsr_dp (
    input  logic                           clk,
    input  logic                           rst_n,
    input  ldsr_pkg::ctrl_t                ctrl,
    input  logic                           go,
    input  logic [7:0]                     dev_addr,
    input  logic [ldsr_pkg::CNT_W-1:0]     period,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [ldsr_pkg::TDATA_W-1:0]   s_tdata,
    input  logic [0:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [7:0]                     m_tdata,
    output logic [0:0]                     m_tuser,
    output logic                           m_tlast,
    output ldsr_pkg::stat_t                stat
);

    logic                              op_reg;
    logic [ldsr_pkg::COL_W-1:0]        col_reg;
    logic [ldsr_pkg::IROW_W-1:0]       irow_reg;
    logic [ldsr_pkg::CH_W-1:0]         ch_reg;

    logic [ldsr_pkg::ROW_W-1:0]        row_reg;
    logic [ldsr_pkg::CNT_W-1:0]        tick_reg;
    logic                              wait_flag_reg;
    logic                              fill_reg;
    logic [ldsr_pkg::COL_W-1:0]        j_reg;
    logic [ldsr_pkg::COL_W-1:0]        j_next;
    logic [ldsr_pkg::COL_W-1:0]        first_reg;
    logic [ldsr_pkg::COL_W-1:0]        last_reg;
    logic                              found_reg;
    logic [ldsr_pkg::DEPTH-1:0]        frame_vld_reg;
    logic [ldsr_pkg::DEPTH-1:0]        shadow_vld_reg;
    logic                              fvld_rd_reg;
    logic                              svld_rd_reg;

    logic                              out_valid_reg;
    logic [7:0]                        out_byte_reg;
    logic                              out_eof_reg;
    logic                              out_last_reg;

    logic [ldsr_pkg::IDX_W-1:0]        rd_idx;
    logic [ldsr_pkg::IDX_W-1:0]        cur_idx;
    logic [ldsr_pkg::IDX_W-1:0]        wr_idx;
    logic                              in_range;
    logic [7:0]                        frame_rdata;
    logic [7:0]                        shadow_rdata;
    logic [7:0]                        cell_byte;
    logic [7:0]                        shadow_val;
    logic                              differ;
    logic                              at_last;
    logic                              frame_we;
    logic                              shadow_we;
    logic                              emit;
    logic                              out_free;
    logic [7:0]                        byte_sel;
    logic                              eof_sel;
    logic                              last_sel;

    assign s_tready = (ctrl.act == ldsr_pkg::A_LATCH);
    assign out_free = !out_valid_reg || m_tready;
    assign at_last  = (j_reg == last_reg);

    // The column pointer moves ahead of the read, so read data always shows cell j_reg.
    always_comb
    begin
        j_next = j_reg;
        if (go)
        begin
            case (ctrl.act)
                ldsr_pkg::A_START:      j_next = '0;
                ldsr_pkg::A_SCAN:       j_next = stat.scan_more ? j_reg + 1'b1 : j_reg;
                ldsr_pkg::A_LOAD_FIRST: j_next = first_reg;
                ldsr_pkg::A_CELL:       j_next = stat.cell_more ? j_reg + 1'b1 : j_reg;
                default:                j_next = j_reg;
            endcase
        end
    end

    assign rd_idx  = ldsr_pkg::IDX_W'(32'(row_reg) * ldsr_pkg::CHARS + 32'(j_next));
    assign cur_idx = ldsr_pkg::IDX_W'(32'(row_reg) * ldsr_pkg::CHARS + 32'(j_reg));
    assign wr_idx  = ldsr_pkg::IDX_W'(32'(irow_reg) * ldsr_pkg::CHARS + 32'(col_reg));
    assign in_range = (32'(col_reg) < ldsr_pkg::CHARS) && (32'(irow_reg) < ldsr_pkg::LINES);

    assign frame_we  = go && (ctrl.act == ldsr_pkg::A_WRITE) && in_range;
    assign shadow_we = go && (ctrl.act == ldsr_pkg::A_CELL);
    assign emit      = go && (ctrl.sel != ldsr_pkg::SEL_NONE);

    ldsr_ram #(
        .WIDTH (8),
        .DEPTH (ldsr_pkg::DEPTH)
    ) u_frame (
        .clk   (clk),
        .we    (frame_we),
        .waddr (wr_idx),
        .wdata (ch_reg),
        .raddr (rd_idx),
        .rdata (frame_rdata)
    );

    ldsr_ram #(
        .WIDTH (8),
        .DEPTH (ldsr_pkg::DEPTH)
    ) u_shadow (
        .clk   (clk),
        .we    (shadow_we),
        .waddr (cur_idx),
        .wdata (cell_byte),
        .raddr (rd_idx),
        .rdata (shadow_rdata)
    );

    // Unwritten frame cells hold spaces, and a stored zero is shown as a space.
    always_comb
    begin
        cell_byte = fvld_rd_reg ? frame_rdata : ldsr_pkg::SPACE;
        if (cell_byte == 8'h00)
        begin
            cell_byte = ldsr_pkg::SPACE;
        end
        shadow_val = svld_rd_reg ? shadow_rdata : (fill_reg ? ldsr_pkg::SPACE : 8'h00);
    end

    assign differ = (cell_byte != shadow_val);

    always_comb
    begin
        stat.item_valid = s_tvalid;
        stat.is_write   = !op_reg;
        stat.wait_set   = wait_flag_reg;
        stat.clr_due    = (tick_reg > period) || (tick_reg == ldsr_pkg::CNT_MAX);
        stat.scan_more  = (32'(j_reg) != ldsr_pkg::CHARS - 1);
        stat.not_found  = !found_reg;
        stat.cell_more  = !at_last;
        stat.out_free   = out_free;
    end

    always_comb
    begin
        case (ctrl.sel)
            ldsr_pkg::SEL_ADDR:   byte_sel = dev_addr;
            ldsr_pkg::SEL_CLEAR:  byte_sel = ldsr_pkg::CMD_CLEAR;
            ldsr_pkg::SEL_CURSOR: byte_sel = ldsr_pkg::CMD_CURSOR;
            ldsr_pkg::SEL_TEXT:   byte_sel = ldsr_pkg::CMD_TEXT;
            ldsr_pkg::SEL_POS:    byte_sel = 8'((32'(row_reg) << ldsr_pkg::POS_SHIFT)
                                                + 32'(first_reg));
            ldsr_pkg::SEL_CELL:   byte_sel = cell_byte;
            default:              byte_sel = 8'h00;
        endcase
        case (ctrl.eof)
            ldsr_pkg::F_YES:     eof_sel = 1'b1;
            ldsr_pkg::F_AT_LAST: eof_sel = at_last;
            default:             eof_sel = 1'b0;
        endcase
        case (ctrl.lst)
            ldsr_pkg::F_YES:     last_sel = 1'b1;
            ldsr_pkg::F_AT_LAST: last_sel = at_last;
            default:             last_sel = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (go && (ctrl.act == ldsr_pkg::A_LATCH) && s_tvalid)
        begin
            op_reg   <= s_tuser[0];
            col_reg  <= s_tdata[4:0];
            irow_reg <= s_tdata[7:5];
            ch_reg   <= s_tdata[15:8];
        end
        if (emit)
        begin
            out_byte_reg <= byte_sel;
            out_eof_reg  <= eof_sel;
            out_last_reg <= last_sel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg        <= '0;
            tick_reg       <= '0;
            wait_flag_reg  <= 1'b0;
            fill_reg       <= 1'b0;
            j_reg          <= '0;
            first_reg      <= '0;
            last_reg       <= '0;
            found_reg      <= 1'b0;
            frame_vld_reg  <= '0;
            shadow_vld_reg <= '0;
            fvld_rd_reg    <= 1'b0;
            svld_rd_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            j_reg       <= j_next;
            fvld_rd_reg <= frame_vld_reg[rd_idx];
            svld_rd_reg <= shadow_vld_reg[rd_idx];

            if (frame_we)
            begin
                frame_vld_reg[wr_idx] <= 1'b1;
            end
            if (shadow_we)
            begin
                shadow_vld_reg[cur_idx] <= 1'b1;
            end

            if (go)
            begin
                case (ctrl.act)
                    ldsr_pkg::A_UNWAIT:
                    begin
                        wait_flag_reg <= 1'b0;
                    end
                    ldsr_pkg::A_CLEAR:
                    begin
                        // Shadow now reads as all spaces until cells are rewritten.
                        shadow_vld_reg <= '0;
                        fill_reg       <= 1'b1;
                        tick_reg       <= '0;
                        wait_flag_reg  <= 1'b1;
                    end
                    ldsr_pkg::A_START:
                    begin
                        found_reg <= 1'b0;
                        if (tick_reg != ldsr_pkg::CNT_MAX)
                        begin
                            tick_reg <= tick_reg + 1'b1;
                        end
                    end
                    ldsr_pkg::A_SCAN:
                    begin
                        if (differ)
                        begin
                            if (!found_reg)
                            begin
                                first_reg <= j_reg;
                            end
                            found_reg <= 1'b1;
                            last_reg  <= j_reg;
                        end
                    end
                    ldsr_pkg::A_FINISH, ldsr_pkg::A_ADV_ROW:
                    begin
                        if (ctrl.act == ldsr_pkg::A_FINISH)
                        begin
                            wait_flag_reg <= 1'b1;
                        end
                        if (32'(row_reg) == ldsr_pkg::LINES - 1)
                        begin
                            row_reg <= '0;
                        end
                        else
                        begin
                            row_reg <= row_reg + 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_byte_reg;
    assign m_tuser[0] = out_eof_reg;
    assign m_tlast    = out_last_reg;

endmodule

@@ hdl/lcd_dirty_span_refresher_unit.sv @@
// Top level: configuration registers, control sequencer and datapath.
// A write word and a skipped tick send no bytes; a clear tick sends 3 bytes.
// A refresh tick scans its row one cell per cycle from the frame and shadow RAM read
// ports and sends n + 5 bytes for a span of n cells, none for a clean row.
// One word is worked on at a time; output stalls hold the sequencer byte for byte.
// Reset (rst_n low, asynchronous) clears frame to spaces, shadow to zeros, row, count
// and wait flag through valid bits at once, and loads the register reset values.
module lcd_dirty_span_refresher_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [ldsr_pkg::TDATA_W-1:0] s_tdata,  // col[4:0], row[7:5], ch[15:8]
    input  logic [0:0]                   s_tuser,  // op[0]
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [7:0]                   m_tdata,  // spi_byte[7:0]
    output logic [0:0]                   m_tuser,  // end_of_frame[0]
    output logic                         m_tlast,
    input  logic                         cfg_we,
    input  logic [0:0]                   cfg_index,
    input  logic [ldsr_pkg::CFG_W-1:0]   cfg_data
);

    logic [7:0]                    dev_addr_reg;
    logic [ldsr_pkg::CNT_W-1:0]    period_reg;
    ldsr_pkg::ctrl_t               ctrl;
    ldsr_pkg::stat_t               stat;
    logic                          go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_addr_reg <= ldsr_pkg::ADDR_RESET;
            period_reg   <= ldsr_pkg::PERIOD_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index[0])
                ldsr_pkg::CFG_DEV_ADDR: dev_addr_reg <= cfg_data[7:0];
                ldsr_pkg::CFG_PERIOD:   period_reg   <= cfg_data[ldsr_pkg::CNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    ldsr_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl),
        .go    (go)
    );

    ldsr_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .go       (go),
        .dev_addr (dev_addr_reg),
        .period   (period_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .stat     (stat)
    );

endmodule

@@ verif/lcd_dirty_span_refresher_unit_tb.sv @@
// Self-checking testbench for the LCD dirty-span refresher with a scoreboard.
module lcd_dirty_span_refresher_unit_tb;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    localparam int DRAIN_CYCLES = 60;
    localparam int LIMIT_CYCLES = 1000000;

    typedef struct packed {
        logic [7:0] spi_byte;
        logic       eof;
        logic       lst;
    } lcd_byte_t;

    // Tracks frame, shadow, row and tick counter and queues the bytes each word should cause.
    class lcd_refresh_scoreboard;
        logic [7:0]                 frame [ldsr_pkg::DEPTH];
        logic [7:0]                 shadow [ldsr_pkg::DEPTH];
        logic [ldsr_pkg::ROW_W-1:0] row_ptr;
        logic [ldsr_pkg::CNT_W-1:0] active_ticks;
        logic                       skip_next;
        logic [7:0]                 dev_addr;
        logic [ldsr_pkg::CNT_W-1:0] period;
        lcd_byte_t                  expected_bytes[$];
        int unsigned                mismatches;

        function new();
            for (int i = 0; i < ldsr_pkg::DEPTH; i++)
            begin
                frame[i]  = ldsr_pkg::SPACE;
                shadow[i] = 8'h00;
            end
            row_ptr      = '0;
            active_ticks = '0;
            skip_next    = 1'b0;
            dev_addr     = ldsr_pkg::ADDR_RESET;
            period       = ldsr_pkg::PERIOD_RESET;
            mismatches   = 0;
        endfunction

        function void set_register(logic [0:0] idx, logic [ldsr_pkg::CFG_W-1:0] value);
            if (idx == ldsr_pkg::CFG_DEV_ADDR)
                dev_addr = value[7:0];
            else
                period = value[ldsr_pkg::CNT_W-1:0];
        endfunction

        function void push_byte(logic [7:0] b, logic eof, logic lst);
            lcd_byte_t item;
            item.spi_byte = b;
            item.eof      = eof;
            item.lst      = lst;
            expected_bytes.push_back(item);
        endfunction

        function void refresh_row();
            int base;
            int first_col;
            int last_col;
            base      = int'(row_ptr) * ldsr_pkg::CHARS;
            first_col = -1;
            last_col  = -1;
            for (int j = 0; j < ldsr_pkg::CHARS; j++)
            begin
                if (frame[base + j] == 8'h00)
                    frame[base + j] = ldsr_pkg::SPACE;
                if (frame[base + j] != shadow[base + j])
                begin
                    if (first_col < 0)
                        first_col = j;
                    last_col = j;
                end
            end
            if (first_col >= 0)
            begin
                push_byte(dev_addr, 1'b0, 1'b0);
                push_byte(ldsr_pkg::CMD_CURSOR, 1'b0, 1'b0);
                push_byte(8'((int'(row_ptr) << ldsr_pkg::POS_SHIFT) + first_col), 1'b1, 1'b0);
                push_byte(dev_addr, 1'b0, 1'b0);
                push_byte(ldsr_pkg::CMD_TEXT, 1'b0, 1'b0);
                for (int j = first_col; j <= last_col; j++)
                begin
                    push_byte(frame[base + j], j == last_col, j == last_col);
                    shadow[base + j] = frame[base + j];
                end
                skip_next = 1'b1;
            end
            row_ptr = (int'(row_ptr) == ldsr_pkg::LINES - 1) ? '0 : row_ptr + 1'b1;
        endfunction

        function void note_word(logic op, logic [4:0] col, logic [2:0] row, logic [7:0] ch);
            if (op == OP_WRITE)
            begin
                if (int'(col) < ldsr_pkg::CHARS && int'(row) < ldsr_pkg::LINES)
                    frame[int'(row) * ldsr_pkg::CHARS + int'(col)] = ch;
                return;
            end
            if (skip_next)
            begin
                skip_next = 1'b0;
                return;
            end
            // The counter saturates, so a full count forces a clear even at the largest period.
            if (active_ticks > period || active_ticks == ldsr_pkg::CNT_MAX)
            begin
                push_byte(dev_addr, 1'b0, 1'b0);
                push_byte(ldsr_pkg::CMD_CLEAR, 1'b0, 1'b0);
                push_byte(8'h00, 1'b1, 1'b1);
                for (int i = 0; i < ldsr_pkg::DEPTH; i++)
                    shadow[i] = ldsr_pkg::SPACE;
                active_ticks = '0;
                skip_next    = 1'b1;
                return;
            end
            active_ticks = active_ticks + 1'b1;
            refresh_row();
        endfunction

        function void check_byte(logic [7:0] b, logic eof, logic lst);
            lcd_byte_t want;
            if (expected_bytes.size() == 0)
            begin
                $error("spi_byte: expected none, actual %02h", b);
                mismatches++;
                return;
            end
            want = expected_bytes.pop_front();
            if (want.spi_byte !== b)
            begin
                $error("spi_byte: expected %02h, actual %02h", want.spi_byte, b);
                mismatches++;
            end
            if (want.eof !== eof)
            begin
                $error("end_of_frame: expected %0b, actual %0b", want.eof, eof);
                mismatches++;
            end
            if (want.lst !== lst)
            begin
                $error("last: expected %0b, actual %0b", want.lst, lst);
                mismatches++;
            end
        endfunction
    endclass

    logic                         clk;
    logic                         rst_n;
    logic                         s_tvalid;
    logic                         s_tready;
    logic [ldsr_pkg::TDATA_W-1:0] s_tdata;   // col[4:0], row[7:5], ch[15:8]
    logic [0:0]                   s_tuser;   // op[0]
    logic                         m_tvalid;
    logic                         m_tready;
    logic [7:0]                   m_tdata;   // spi_byte[7:0]
    logic [0:0]                   m_tuser;   // end_of_frame[0]
    logic                         m_tlast;
    logic                         cfg_we;
    logic [0:0]                   cfg_index;
    logic [ldsr_pkg::CFG_W-1:0]   cfg_data;

    lcd_refresh_scoreboard sb;
    bit                    calm;

    lcd_dirty_span_refresher_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #(12 * LIMIT_CYCLES);
        $display("lcd_dirty_span_refresher_unit_tb NOT OK");
        $finish;
    end

    // The receiver stalls about 18 percent of the time except during the calm phase.
    initial m_tready <= 1'b0;
    always @(posedge clk)
        m_tready <= calm || ($urandom_range(0, 99) >= 18);

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_byte(m_tdata, m_tuser[0], m_tlast);
    end

    task automatic send_word(input logic op, input logic [4:0] col, input logic [2:0] row,
                             input logic [7:0] ch);
        int gap;
        gap = (!calm && $urandom_range(0, 99) < 18) ? $urandom_range(1, 8) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {ch, row, col};
        do @(posedge clk); while (!s_tready);
        sb.note_word(op, col, row, ch);
    endtask

    // Words that cause no bytes may still be in flight once the queue is empty.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.expected_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic load_settings(input logic [7:0] addr,
                                 input logic [ldsr_pkg::CNT_W-1:0] period);
        cfg_we    <= 1'b1;
        cfg_index <= ldsr_pkg::CFG_DEV_ADDR;
        cfg_data  <= ldsr_pkg::CFG_W'(addr);
        @(posedge clk);
        sb.set_register(ldsr_pkg::CFG_DEV_ADDR, ldsr_pkg::CFG_W'(addr));
        cfg_index <= ldsr_pkg::CFG_PERIOD;
        cfg_data  <= ldsr_pkg::CFG_W'(period);
        @(posedge clk);
        sb.set_register(ldsr_pkg::CFG_PERIOD, ldsr_pkg::CFG_W'(period));
        cfg_we <= 1'b0;
    endtask

    task automatic send_random_words(input int count);
        logic [4:0] col;
        logic [2:0] row;
        logic [7:0] ch;
        for (int i = 0; i < count; i++)
        begin
            col = 5'($urandom_range(0, 31));
            row = 3'($urandom_range(0, 7));
            ch  = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 99) < 35)
                send_word(OP_TICK, col, row, ch);
            else
            begin
                if ($urandom_range(0, 99) < 85)
                begin
                    col = 5'($urandom_range(0, ldsr_pkg::CHARS - 1));
                    row = 3'($urandom_range(0, ldsr_pkg::LINES - 1));
                end
                else
                begin
                    case ($urandom_range(0, 2))
                        0: col = 5'($urandom_range(ldsr_pkg::CHARS, 31));
                        1: row = 3'($urandom_range(ldsr_pkg::LINES, 7));
                        default:
                        begin
                            col = 5'($urandom_range(ldsr_pkg::CHARS, 31));
                            row = 3'($urandom_range(ldsr_pkg::LINES, 7));
                        end
                    endcase
                end
                case ($urandom_range(0, 5))
                    0: ch = 8'h00;
                    1: ch = ldsr_pkg::SPACE;
                    default: ;
                endcase
                send_word(OP_WRITE, col, row, ch);
            end
        end
    endtask

    initial
    begin
        sb        = new();
        calm      = 1'b0;
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= OP_WRITE;
        cfg_we    <= 1'b0;
        cfg_index <= ldsr_pkg::CFG_DEV_ADDR;
        cfg_data  <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part with the reset register values.
        send_word(OP_WRITE, 5'd0, 3'd0, 8'h41);
        send_word(OP_WRITE, 5'd19, 3'd3, 8'hFF);
        send_word(OP_WRITE, 5'd20, 3'd0, 8'h55);
        send_word(OP_WRITE, 5'd31, 3'd7, 8'hAA);
        send_word(OP_WRITE, 5'd5, 3'd4, 8'h33);
        send_word(OP_WRITE, 5'd3, 3'd1, 8'h00);
        // The shadow starts at zero, so each row goes out whole once.
        repeat (8) send_word(OP_TICK, 5'd0, 3'd0, 8'd0);
        send_word(OP_TICK, 5'd31, 3'd7, 8'hFF);
        send_word(OP_WRITE, 5'd7, 3'd1, 8'h7E);
        send_word(OP_TICK, 5'd0, 3'd0, 8'd0);
        send_word(OP_TICK, 5'd0, 3'd0, 8'd0);
        // A zero over a space already shown must not widen the span.
        send_word(OP_WRITE, 5'd2, 3'd2, 8'h00);
        send_word(OP_WRITE, 5'd15, 3'd2, 8'h80);
        send_word(OP_TICK, 5'd0, 3'd0, 8'd0);
        send_word(OP_TICK, 5'd0, 3'd0, 8'd0);
        send_word(OP_TICK, 5'd0, 3'd0, 8'd0);
        send_word(OP_TICK, 5'd31, 3'd7, 8'hFF);
        wait_drained();

        load_settings(8'hFF, 10'd0);
        send_random_words(65);
        wait_drained();

        load_settings(8'h00, 10'd3);
        calm = 1'b1;
        send_random_words(65);
        wait_drained();
        calm = 1'b0;

        load_settings(8'($urandom_range(0, 255)), 10'd1);
        send_random_words(65);
        wait_drained();

        load_settings(8'($urandom_range(0, 255)), 10'($urandom_range(2, 40)));
        send_random_words(65);
        wait_drained();

        if (sb.mismatches == 0 && sb.expected_bytes.size() == 0)
            $display("lcd_dirty_span_refresher_unit_tb OK");
        else
            $display("lcd_dirty_span_refresher_unit_tb NOT OK");
        $finish;
    end

endmodule
